[design/cca_pkg.sv]
// ----------------------------------------------------------------------------
// Clock calendar package
// Item types, field codes and the month length table shared by the clock
// calendar modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cca_pkg;

   localparam logic       OP_TICK     = 1'b0;
   localparam logic       OP_BUTTON   = 1'b1;

   localparam logic [2:0] TARGET_HOUR   = 3'd0;
   localparam logic [2:0] TARGET_MINUTE = 3'd1;
   localparam logic [2:0] TARGET_DAY    = 3'd2;
   localparam logic [2:0] TARGET_MONTH  = 3'd3;
   localparam logic [2:0] TARGET_YEAR   = 3'd4;

   localparam logic [5:0]  SECOND_MAX = 6'd59;
   localparam logic [5:0]  MINUTE_MAX = 6'd59;
   localparam logic [4:0]  HOUR_MAX   = 5'd23;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;
   localparam logic [13:0] YEAR_MAX   = 14'd9999;

   localparam logic [5:0]  RESET_SECOND       = 6'd0;
   localparam logic [5:0]  RESET_MINUTE       = 6'd0;
   localparam logic [4:0]  RESET_HOUR         = 5'd0;
   localparam logic [4:0]  RESET_DAY          = 5'd1;
   localparam logic [3:0]  RESET_MONTH        = 4'd7;
   localparam logic [13:0] RESET_YEAR         = 14'd2021;
   localparam logic [4:0]  RESET_ALARM_HOUR   = 5'd0;
   localparam logic [5:0]  RESET_ALARM_MINUTE = 6'd1;

   typedef struct packed {
      logic       operation;
      logic [2:0] target;
      logic       up;
      logic       alarm_switch;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
      logic        buzzer;
      logic        alarm_blink;
   } rsp_item_type;

   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [4:0]  alarm_hour;
      logic [5:0]  alarm_minute;
   } clock_state_type;

   function automatic logic [4:0] month_length(input logic [3:0] month,
                                               input logic [13:0] year);
      logic [4:0] len;
      case (month)
         4'd2:                     len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[design/clock_calendar_with_alarm_top.sv]
// ----------------------------------------------------------------------------
// Clock calendar with alarm
// Real-time clock and calendar with an alarm, driven by tick and button items.
// An accepted item's result is registered. Throughput: one item per cycle
// while req_stall is low, set by the combinational state update; a
// two-entry output buffer lets an item enter while a result still waits.
// Reset: synchronous; clock and alarm return to their start values and the
// output buffer empties.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_calendar_with_alarm_top (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  cca_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output cca_pkg::rsp_item_type rsp_item
);

   cca_pkg::clock_state_type state_ff;
   cca_pkg::clock_state_type state_in;
   cca_pkg::rsp_item_type    result;
   cca_pkg::rsp_item_type    main_ff;
   cca_pkg::rsp_item_type    skid_ff;
   logic                     main_valid_ff;
   logic                     skid_valid_ff;
   logic                     accept;
   logic                     take;

   cca_update u_update (
      .cur_state  (state_ff),
      .item       (req_item),
      .next_state (state_in),
      .result     (result)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = main_valid_ff && !rsp_stall;
   assign rsp_valid = main_valid_ff;
   assign rsp_item  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.second       <= cca_pkg::RESET_SECOND;
         state_ff.minute       <= cca_pkg::RESET_MINUTE;
         state_ff.hour         <= cca_pkg::RESET_HOUR;
         state_ff.day          <= cca_pkg::RESET_DAY;
         state_ff.month        <= cca_pkg::RESET_MONTH;
         state_ff.year         <= cca_pkg::RESET_YEAR;
         state_ff.alarm_hour   <= cca_pkg::RESET_ALARM_HOUR;
         state_ff.alarm_minute <= cca_pkg::RESET_ALARM_MINUTE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || take) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            main_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!main_valid_ff || take) begin
            main_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

endmodule

`default_nettype wire

[design/cca_update.sv]
// ----------------------------------------------------------------------------
// Clock calendar update
// Works out the next clock, calendar and alarm state for one item and the
// result item that shows it.
// ----------------------------------------------------------------------------
`default_nettype none

module cca_update (
   input  cca_pkg::clock_state_type cur_state,
   input  cca_pkg::req_item_type    item,
   output cca_pkg::clock_state_type next_state,
   output cca_pkg::rsp_item_type    result
);

   logic [4:0] len;
   logic       buzz;

   assign len = cca_pkg::month_length(cur_state.month, cur_state.year);

   always_comb begin
      next_state = cur_state;
      if (item.operation == cca_pkg::OP_TICK) begin
         if (cur_state.second < cca_pkg::SECOND_MAX) begin
            next_state.second = cur_state.second + 6'd1;
         end else begin
            next_state.second = 6'd0;
            if (cur_state.minute < cca_pkg::MINUTE_MAX) begin
               next_state.minute = cur_state.minute + 6'd1;
            end else begin
               next_state.minute = 6'd0;
               if (cur_state.hour < cca_pkg::HOUR_MAX) begin
                  next_state.hour = cur_state.hour + 5'd1;
               end else begin
                  next_state.hour = 5'd0;
                  if (cur_state.day < len) begin
                     next_state.day = cur_state.day + 5'd1;
                  end else begin
                     next_state.day = 5'd1;
                     if (cur_state.month < cca_pkg::MONTH_MAX) begin
                        next_state.month = cur_state.month + 4'd1;
                     end else begin
                        next_state.month = 4'd1;
                        next_state.year  = (cur_state.year >= cca_pkg::YEAR_MAX) ?
                                           14'd0 : cur_state.year + 14'd1;
                     end
                  end
               end
            end
         end
      end else begin
         unique case (item.target)
            cca_pkg::TARGET_HOUR: begin
               if (item.alarm_switch) begin
                  if (item.up) begin
                     next_state.alarm_hour = (cur_state.alarm_hour >= cca_pkg::HOUR_MAX) ?
                                             5'd0 : cur_state.alarm_hour + 5'd1;
                  end else begin
                     next_state.alarm_hour = (cur_state.alarm_hour == 5'd0) ?
                                             cca_pkg::HOUR_MAX : cur_state.alarm_hour - 5'd1;
                  end
               end else begin
                  if (item.up) begin
                     next_state.hour = (cur_state.hour >= cca_pkg::HOUR_MAX) ?
                                       5'd0 : cur_state.hour + 5'd1;
                  end else begin
                     next_state.hour = (cur_state.hour == 5'd0) ?
                                       cca_pkg::HOUR_MAX : cur_state.hour - 5'd1;
                  end
                  next_state.second = 6'd0;
               end
            end
            cca_pkg::TARGET_MINUTE: begin
               if (item.alarm_switch) begin
                  if (item.up) begin
                     next_state.alarm_minute =
                        (cur_state.alarm_minute >= cca_pkg::MINUTE_MAX) ?
                        6'd0 : cur_state.alarm_minute + 6'd1;
                  end else begin
                     next_state.alarm_minute = (cur_state.alarm_minute == 6'd0) ?
                        cca_pkg::MINUTE_MAX : cur_state.alarm_minute - 6'd1;
                  end
               end else begin
                  if (item.up) begin
                     next_state.minute = (cur_state.minute >= cca_pkg::MINUTE_MAX) ?
                                         6'd0 : cur_state.minute + 6'd1;
                  end else begin
                     next_state.minute = (cur_state.minute == 6'd0) ?
                                         cca_pkg::MINUTE_MAX : cur_state.minute - 6'd1;
                  end
                  next_state.second = 6'd0;
               end
            end
            cca_pkg::TARGET_DAY: begin
               if (item.up) begin
                  next_state.day = (cur_state.day >= len) ? 5'd1 : cur_state.day + 5'd1;
               end else begin
                  next_state.day = (cur_state.day > 5'd1) ? cur_state.day - 5'd1 : len;
               end
            end
            cca_pkg::TARGET_MONTH: begin
               if (item.up) begin
                  next_state.month = (cur_state.month >= cca_pkg::MONTH_MAX) ?
                                     4'd1 : cur_state.month + 4'd1;
               end else begin
                  next_state.month = (cur_state.month <= 4'd1) ?
                                     cca_pkg::MONTH_MAX : cur_state.month - 4'd1;
               end
               next_state.day = 5'd1;
            end
            cca_pkg::TARGET_YEAR: begin
               if (item.up) begin
                  next_state.year = (cur_state.year >= cca_pkg::YEAR_MAX) ?
                                    14'd0 : cur_state.year + 14'd1;
               end else begin
                  next_state.year = (cur_state.year == 14'd0) ?
                                    cca_pkg::YEAR_MAX : cur_state.year - 14'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign buzz = item.alarm_switch
              && (next_state.hour == next_state.alarm_hour)
              && (next_state.minute == next_state.alarm_minute);

   always_comb begin
      result.second       = next_state.second;
      result.minute       = next_state.minute;
      result.hour         = next_state.hour;
      result.day          = next_state.day;
      result.month        = next_state.month;
      result.year         = next_state.year;
      result.alarm_hour   = next_state.alarm_hour;
      result.alarm_minute = next_state.alarm_minute;
      result.buzzer       = buzz;
      result.alarm_blink  = buzz && !next_state.second[0];
   end

endmodule

`default_nettype wire
